// ===== rtl/jsfe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the JSON string field extractor.
// No dependencies; imported by every module of the block.
package jsfe_pkg;

  localparam int KEY_LEN = 16;
  localparam int ARR_LEN = 4;
  localparam int MAX_RES = 3;

  typedef enum logic [2:0] {
    PH_SEARCH = 3'd0,
    PH_COLON  = 3'd1,
    PH_SPACE  = 3'd2,
    PH_STRING = 3'd3,
    PH_DONE   = 3'd4,
    PH_BAD    = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOTFOUND  = 3'd1,
    ST_MALFORMED = 3'd2,
    ST_UNTERM    = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef logic [4:0] match_t;
  typedef logic [1:0] rcount_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // "translatedText" including both quotes
  localparam logic [7:0] KEY_PAT [KEY_LEN] = '{
    8'h22, 8'h74, 8'h72, 8'h61, 8'h6E, 8'h73, 8'h6C, 8'h61,
    8'h74, 8'h65, 8'h64, 8'h54, 8'h65, 8'h78, 8'h74, 8'h22
  };

  typedef struct packed {
    logic       item_kind;
    logic [7:0] out_byte;
    status_t    status;
    logic       run_last;
  } result_t;

  typedef struct packed {
    rcount_t                   count;
    result_t [MAX_RES-1:0]     item;
  } res_group_t;

endpackage

// ===== rtl/jsfe_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces: body bytes in, result items out, mode register write.
// No dependencies.
interface jsfe_body_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_body;
  modport source (output valid, in_byte, end_of_body, input ready);
  modport sink (input valid, in_byte, end_of_body, output ready);
endinterface

interface jsfe_result_if;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       run_last;
  modport source (output valid, item_kind, out_byte, status, run_last, input ready);
  modport sink (input valid, item_kind, out_byte, status, run_last, output ready);
endinterface

interface jsfe_cfg_if;
  logic valid;
  logic ready;
  logic format_mode;
  modport source (output valid, format_mode, input ready);
  modport sink (input valid, format_mode, output ready);
endinterface

// ===== rtl/jsfe_parse.sv =====
`timescale 1ns / 1ps
// Parse state and per-byte step logic: marker search, colon/quote checks,
// unescaping and end status. Depends on jsfe_pkg.
module jsfe_parse (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  format_mode,
  input  logic [7:0]            in_byte,
  input  logic                  end_of_body,
  output jsfe_pkg::res_group_t  res
);
  import jsfe_pkg::*;

  phase_t phase, phase_next;
  match_t match_length, match_length_next;
  logic   pending_backslash, pending_backslash_next;
  logic   content_seen, content_seen_next;

  logic       is_space;
  logic       e_bs, e_byte;
  logic [7:0] byte_val;
  status_t    end_st;
  logic [3:0] kj;
  logic [1:0] aj;
  rcount_t    k;

  assign is_space = (in_byte == CH_SPACE) || (in_byte >= CH_TAB && in_byte <= CH_CR);

  always_comb begin
    phase_next             = phase;
    match_length_next      = match_length;
    pending_backslash_next = pending_backslash;
    content_seen_next      = content_seen;
    e_bs     = 1'b0;
    e_byte   = 1'b0;
    byte_val = in_byte;
    kj = (match_length >= match_t'(KEY_LEN)) ? 4'd0 : match_length[3:0];
    aj = (match_length >= match_t'(ARR_LEN)) ? 2'd0 : match_length[1:0];

    case (phase)
      PH_SEARCH: begin
        if (format_mode) begin
          // [[[" : every fallback ends on a '[' compare
          if (aj == 2'd3) begin
            if (in_byte == CH_QUOTE) begin
              phase_next        = PH_STRING;
              match_length_next = '0;
            end else if (in_byte == CH_LBRACK) begin
              match_length_next = match_t'(3);
            end else begin
              match_length_next = '0;
            end
          end else if (in_byte == CH_LBRACK) begin
            match_length_next = match_t'(aj) + 5'd1;
          end else begin
            match_length_next = '0;
          end
        end else begin
          // key fallback always lands on the opening quote
          if (in_byte == KEY_PAT[kj]) begin
            if (kj == 4'(KEY_LEN - 1)) begin
              phase_next        = PH_COLON;
              match_length_next = '0;
            end else begin
              match_length_next = match_t'(kj) + 5'd1;
            end
          end else if (in_byte == KEY_PAT[0]) begin
            match_length_next = match_t'(1);
          end else begin
            match_length_next = '0;
          end
        end
      end
      PH_COLON: begin
        if (in_byte == CH_COLON) phase_next = PH_SPACE;
      end
      PH_SPACE: begin
        if (in_byte == CH_QUOTE) phase_next = PH_STRING;
        else if (!is_space) phase_next = PH_BAD;
      end
      PH_STRING: begin
        if (pending_backslash) begin
          pending_backslash_next = 1'b0;
          content_seen_next      = 1'b1;
          e_byte                 = 1'b1;
          if (in_byte == CH_QUOTE) byte_val = CH_QUOTE;
          else if (in_byte == CH_BSLASH) byte_val = CH_BSLASH;
          else if (in_byte == CH_N) byte_val = CH_LF;
          else if (in_byte == CH_R) byte_val = CH_CR;
          else if (in_byte == CH_T) byte_val = CH_TAB;
          else e_bs = 1'b1;
        end else if (in_byte == CH_BSLASH) begin
          pending_backslash_next = 1'b1;
        end else if (in_byte == CH_QUOTE) begin
          phase_next = PH_DONE;
        end else begin
          e_byte            = 1'b1;
          content_seen_next = 1'b1;
        end
      end
      default: begin
      end
    endcase

    case (phase_next)
      PH_SEARCH: end_st = ST_NOTFOUND;
      PH_STRING: end_st = ST_UNTERM;
      PH_DONE:   end_st = content_seen_next ? ST_OK : ST_EMPTY;
      default:   end_st = ST_MALFORMED;
    endcase

    res.item = '0;
    k        = '0;
    if (e_bs) begin
      res.item[k].out_byte = CH_BSLASH;
      k = k + 2'd1;
    end
    if (e_byte) begin
      res.item[k].out_byte = byte_val;
      k = k + 2'd1;
    end
    if (end_of_body) begin
      res.item[k].item_kind = 1'b1;
      res.item[k].status    = end_st;
      k = k + 2'd1;
    end
    if (k != 2'd0) res.item[k - 2'd1].run_last = 1'b1;
    res.count = k;

    if (end_of_body) begin
      phase_next             = PH_SEARCH;
      match_length_next      = '0;
      pending_backslash_next = 1'b0;
      content_seen_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_SEARCH;
      match_length      <= '0;
      pending_backslash <= 1'b0;
      content_seen      <= 1'b0;
    end else if (step) begin
      phase             <= phase_next;
      match_length      <= match_length_next;
      pending_backslash <= pending_backslash_next;
      content_seen      <= content_seen_next;
    end
  end

endmodule

// ===== rtl/jsfe_res_buf.sv =====
`timescale 1ns / 1ps
// Result register: holds up to three result items of one byte and hands
// them out one per transaction. Depends on jsfe_pkg and jsfe_result_if.
module jsfe_res_buf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  jsfe_pkg::res_group_t  res,
  output logic                  can_load,
  jsfe_result_if.source         result
);
  import jsfe_pkg::*;

  result_t slot [MAX_RES];
  rcount_t count;
  rcount_t rd;
  logic    pop;
  result_t head;

  assign pop      = (count != 2'd0) && result.ready;
  assign can_load = (count == 2'd0) || ((count == 2'd1) && result.ready);
  assign head     = slot[rd];

  assign result.valid     = (count != 2'd0);
  assign result.item_kind = head.item_kind;
  assign result.out_byte  = head.out_byte;
  assign result.status    = head.status;
  assign result.run_last  = head.run_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rd    <= '0;
    end else if (load) begin
      count <= res.count;
      rd    <= '0;
    end else if (pop) begin
      count <= count - 2'd1;
      rd    <= rd + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_RES; i++) slot[i] <= res.item[i];
    end
  end

endmodule

// ===== rtl/json_string_field_extractor_unit.sv =====
`timescale 1ns / 1ps
// Top level of the JSON string field extractor: input register, mode
// register, parse step and result buffer. Depends on jsfe_pkg, jsfe_if.sv, jsfe_parse and jsfe_res_buf.
//
// channel  dir  fields                                   transfer
// body     in   in_byte[7:0], end_of_body                valid & ready
// result   out  item_kind, out_byte[7:0], status[2:0],   valid & ready
//               run_last
// cfg      in   format_mode                              valid & ready
//
// A body byte is registered, parsed when the result buffer can load, and
// its results land in the buffer. One byte per cycle while each byte yields
// at most one result and result.ready is high; a byte with more results
// holds the next one until the single output port takes the last of them.
// Stalls on result.ready back up through the buffer into body.ready.
// rst (synchronous) clears parse state, buffer and format_mode to keyed.
module json_string_field_extractor_unit (
  input  logic          clk,
  input  logic          rst,
  jsfe_body_if.sink     body,
  jsfe_result_if.source result,
  jsfe_cfg_if.sink      cfg
);
  import jsfe_pkg::*;

  logic       format_mode;
  logic       held;
  logic [7:0] held_byte;
  logic       held_eob;
  logic       step;
  logic       can_load;
  res_group_t res;

  assign cfg.ready  = 1'b1;
  assign step       = held && can_load;
  assign body.ready = !held || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode <= 1'b0;
    end else if (cfg.valid) begin
      format_mode <= cfg.format_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (body.valid && body.ready) begin
      held <= 1'b1;
    end else if (step) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (body.valid && body.ready) begin
      held_byte <= body.in_byte;
      held_eob  <= body.end_of_body;
    end
  end

  jsfe_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .format_mode (format_mode),
    .in_byte     (held_byte),
    .end_of_body (held_eob),
    .res         (res)
  );

  jsfe_res_buf u_res_buf (
    .clk      (clk),
    .rst      (rst),
    .load     (step),
    .res      (res),
    .can_load (can_load),
    .result   (result)
  );

endmodule
